// ===== design/partition_extent_allocator_core_macros.svh =====
// Assertion macros used by the partition extent allocator top level.
`ifndef PARTITION_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`define PARTITION_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PEA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Allocator assertion failed.");
`define PEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Allocator assertion failed.");
`else
`define PEA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PEA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/pea_pkg.sv =====
// Types and constants shared by the partition extent allocator modules.
package pea_pkg;

   localparam logic [2:0] CMD_FIND_FREE   = 3'd0;
   localparam logic [2:0] CMD_ALLOCATE    = 3'd1;
   localparam logic [2:0] CMD_READ_OFFSET = 3'd2;
   localparam logic [2:0] CMD_READ_SIZE   = 3'd3;
   localparam logic [2:0] CMD_RELEASE     = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd2;

   localparam logic [1:0] CSR_ACTIVE_ENTRIES = 2'd0;
   localparam logic [1:0] CSR_FIRST_USABLE   = 2'd1;
   localparam logic [1:0] CSR_LAST_USABLE    = 2'd2;
   localparam logic [1:0] CSR_EMPTY_MARKER   = 2'd3;

   localparam int SECTOR_SHIFT = 9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_FINISH
   } pea_state_type;

   typedef struct packed {
      logic [63:0] first;
      logic [63:0] last;
   } pea_extent_type;

   typedef struct packed {
      logic        shift;
      logic        wr_en;
      logic [6:0]  wr_index;
      logic [63:0] wr_start;
      logic [63:0] wr_end;
   } pea_ctl_type;

endpackage

// ===== design/pea_cell.sv =====
// One table entry of the extent ring: holds an extent and passes it to its neighbor.
module pea_cell import pea_pkg::*; #(
   parameter int CELL_ID = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  pea_ctl_type    ctl,
   input  pea_extent_type from_next,
   output pea_extent_type extent
);

   localparam bit         WRITABLE = (CELL_ID < 128);
   localparam logic [6:0] CELL_TAG = 7'(CELL_ID);

   pea_extent_type extent_ff;
   pea_extent_type extent_in;
   logic           hit;

   assign hit = WRITABLE && ctl.wr_en && (ctl.wr_index == CELL_TAG);

   always_comb begin
      extent_in = extent_ff;
      if (ctl.shift) begin
         extent_in = from_next;
      end else if (hit) begin
         extent_in.first = ctl.wr_start;
         extent_in.last  = ctl.wr_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         extent_ff <= '1;
      end else begin
         extent_ff <= extent_in;
      end
   end

   assign extent = extent_ff;

endmodule

// ===== design/pea_ctrl.sv =====
// Command sequencer that walks the extent ring and forms each result item.
module pea_ctrl import pea_pkg::*; #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [2:0]     req_cmd,
   input  logic [6:0]     req_entry_index,
   input  logic [63:0]    req_size_bytes,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [1:0]     rsp_status,
   output logic [6:0]     rsp_found_index,
   output logic [63:0]    rsp_byte_value,
   output logic [63:0]    rsp_start_sector,
   output logic [63:0]    rsp_end_sector,
   input  logic [7:0]     active_entries,
   input  logic [63:0]    first_usable_sector,
   input  logic [63:0]    last_usable_sector,
   input  logic [63:0]    empty_marker,
   input  pea_extent_type head,
   output pea_ctl_type    ctl
);

   localparam int CW   = $clog2(TABLE_ENTRIES + 1);
   localparam int CNTW = (CW > 8) ? CW : 8;
   localparam logic [CNTW-1:0] ENTRIES  = CNTW'(TABLE_ENTRIES);
   localparam logic [CNTW-1:0] LAST_POS = CNTW'(TABLE_ENTRIES - 1);

   pea_state_type  state_ff, state_in;
   logic [2:0]     cmd_ff, cmd_in;
   logic [6:0]     idx_ff, idx_in;
   logic [63:0]    secs_ff, secs_in;
   logic [63:0]    secs_m1_ff, secs_m1_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic           err_ff, err_in;
   logic [CNTW-1:0] pos_ff, pos_in;
   logic [63:0]    cs_ff, cs_in;
   logic [63:0]    ce_ff, ce_in;
   logic           ovf_ff, ovf_in;
   logic           found_ff, found_in;
   logic [6:0]     found_idx_ff, found_idx_in;
   pea_extent_type cap_ff, cap_in;

   logic           rsp_valid_ff;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [6:0]     rsp_found_ff, rsp_found_in;
   logic [63:0]    rsp_bytes_ff, rsp_bytes_in;
   logic [63:0]    rsp_start_ff, rsp_start_in;
   logic [63:0]    rsp_end_ff, rsp_end_in;

   logic           accept;
   logic           load;
   logic           indexed;
   logic [CNTW-1:0] live_count;
   logic [63:0]    quot;
   logic           rem;
   logic [64:0]    first_sum;
   logic [64:0]    next_sum;
   logic           in_range;
   logic           used;
   logic           overlaps;
   logic           alloc_ok;
   logic [63:0]    span;

   assign accept = req_valid && req_ready;
   assign load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign live_count = (CNTW'(active_entries) > ENTRIES) ? ENTRIES : CNTW'(active_entries);
   assign indexed    = (req_cmd >= CMD_ALLOCATE) && (req_cmd <= CMD_RELEASE);
   assign quot       = {{SECTOR_SHIFT{1'b0}}, req_size_bytes[63:SECTOR_SHIFT]};
   assign rem        = |req_size_bytes[SECTOR_SHIFT-1:0];

   assign first_sum = {1'b0, first_usable_sector} + {1'b0, secs_m1_ff};
   assign next_sum  = {1'b0, head.last} + {1'b0, secs_ff};
   assign in_range  = pos_ff < count_ff;
   assign used      = (head.first != empty_marker) && (head.last != empty_marker);
   assign overlaps  = (cs_ff >= head.first) || (ce_ff >= head.first);
   assign alloc_ok  = !ovf_ff && (ce_ff <= last_usable_sector);
   assign span      = cap_ff.last - cap_ff.first + 64'd1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_cmd == CMD_FIND_FREE) ||
                   (indexed && (CNTW'(req_entry_index) < live_count))) begin
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SETUP: state_in = ST_WALK;
         ST_WALK: begin
            if (pos_ff == LAST_POS) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      ctl.shift    = (state_ff == ST_WALK);
      ctl.wr_en    = load && !err_ff &&
                     (((cmd_ff == CMD_ALLOCATE) && alloc_ok) || (cmd_ff == CMD_RELEASE));
      ctl.wr_index = idx_ff;
      ctl.wr_start = (cmd_ff == CMD_RELEASE) ? empty_marker : cs_ff;
      ctl.wr_end   = (cmd_ff == CMD_RELEASE) ? empty_marker : ce_ff;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      secs_in      = secs_ff;
      secs_m1_in   = secs_m1_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      pos_in       = pos_ff;
      cs_in        = cs_ff;
      ce_in        = ce_ff;
      ovf_in       = ovf_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      cap_in       = cap_ff;
      if (accept) begin
         cmd_in   = req_cmd;
         idx_in   = req_entry_index;
         count_in = live_count;
         err_in   = indexed && (CNTW'(req_entry_index) >= live_count);
         if (quot == 64'd0) begin
            secs_in    = 64'd1;
            secs_m1_in = 64'd0;
         end else begin
            secs_in    = quot + {63'd0, rem};
            secs_m1_in = rem ? quot : quot - 64'd1;
         end
      end
      if (state_ff == ST_SETUP) begin
         pos_in       = '0;
         cs_in        = first_usable_sector;
         ce_in        = first_sum[63:0];
         ovf_in       = first_sum[64];
         found_in     = 1'b0;
         found_idx_in = '0;
         cap_in       = '0;
      end
      if (state_ff == ST_WALK) begin
         pos_in = pos_ff + CNTW'(1);
         if (pos_ff == CNTW'(idx_ff)) begin
            cap_in = head;
         end
         if (in_range && !used && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = pos_ff[6:0];
         end
         if ((cmd_ff == CMD_ALLOCATE) && in_range && used && !ovf_ff && overlaps) begin
            if (next_sum[64]) begin
               ovf_in = 1'b1;
            end else begin
               cs_in = head.last + 64'd1;
               ce_in = next_sum[63:0];
            end
         end
      end
   end

   always_comb begin
      rsp_status_in = STATUS_OK;
      rsp_found_in  = idx_ff;
      rsp_bytes_in  = '0;
      rsp_start_in  = '0;
      rsp_end_in    = '0;
      if (err_ff) begin
         rsp_status_in = STATUS_RANGE;
      end else begin
         case (cmd_ff)
            CMD_FIND_FREE: begin
               rsp_status_in = found_ff ? STATUS_OK : STATUS_NO_SPACE;
               rsp_found_in  = found_ff ? found_idx_ff : 7'd0;
            end
            CMD_ALLOCATE: begin
               if (alloc_ok) begin
                  rsp_start_in = cs_ff;
                  rsp_end_in   = ce_ff;
               end else begin
                  rsp_status_in = STATUS_NO_SPACE;
               end
            end
            CMD_READ_OFFSET: begin
               rsp_bytes_in = cap_ff.first << SECTOR_SHIFT;
               rsp_start_in = cap_ff.first;
               rsp_end_in   = cap_ff.last;
            end
            CMD_READ_SIZE: begin
               rsp_bytes_in = span << SECTOR_SHIFT;
               rsp_start_in = cap_ff.first;
               rsp_end_in   = cap_ff.last;
            end
            CMD_RELEASE: begin
               rsp_start_in = cap_ff.first;
               rsp_end_in   = cap_ff.last;
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      secs_ff      <= secs_in;
      secs_m1_ff   <= secs_m1_in;
      count_ff     <= count_in;
      err_ff       <= err_in;
      pos_ff       <= pos_in;
      cs_ff        <= cs_in;
      ce_ff        <= ce_in;
      ovf_ff       <= ovf_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      cap_ff       <= cap_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_bytes_ff  <= rsp_bytes_in;
         rsp_start_ff  <= rsp_start_in;
         rsp_end_ff    <= rsp_end_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_index  = rsp_found_ff;
   assign rsp_byte_value   = rsp_bytes_ff;
   assign rsp_start_sector = rsp_start_ff;
   assign rsp_end_sector   = rsp_end_ff;

endmodule

// ===== design/partition_extent_allocator_core.sv =====
// Partition extent allocator top level: configuration registers, extent ring and sequencer.
// The extent table lives in a ring of TABLE_ENTRIES cells that reset to empty.
// A find_free, allocate, read or release item passes a setup state after acceptance, then
// the ring turns once, one entry per cycle past the sequencer, and comes back to its home
// position before the result is written; the next item can be taken as soon as the result
// appears. An item with an out-of-range index or an unknown command skips the ring walk
// and goes straight to the finish state that writes its result.
// A stalled result holds the next result back but not the acceptance of the next item.
// One item is in work at a time; the user must write configuration registers only while
// no item is in work, as the block itself does not enforce this.
`include "partition_extent_allocator_core_macros.svh"
module partition_extent_allocator_core import pea_pkg::*; #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [6:0]  req_entry_index,
   input  logic [63:0] req_size_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_found_index,
   output logic [63:0] rsp_byte_value,
   output logic [63:0] rsp_start_sector,
   output logic [63:0] rsp_end_sector,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [7:0]  active_entries_ff;
   logic [63:0] first_usable_ff;
   logic [63:0] last_usable_ff;
   logic [63:0] empty_marker_ff;

   pea_ctl_type    ctl;
   pea_extent_type chain [TABLE_ENTRIES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_entries_ff <= 8'd128;
         first_usable_ff   <= 64'd34;
         last_usable_ff    <= 64'd0;
         empty_marker_ff   <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ACTIVE_ENTRIES: active_entries_ff <= csr_data[7:0];
            CSR_FIRST_USABLE:   first_usable_ff   <= csr_data;
            CSR_LAST_USABLE:    last_usable_ff    <= csr_data;
            CSR_EMPTY_MARKER:   empty_marker_ff   <= csr_data;
         endcase
      end
   end

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      pea_cell #(
         .CELL_ID (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .from_next (chain[(g + 1) % TABLE_ENTRIES]),
         .extent    (chain[g])
      );
   end

   pea_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_entry_index     (req_entry_index),
      .req_size_bytes      (req_size_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_found_index     (rsp_found_index),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_start_sector    (rsp_start_sector),
      .rsp_end_sector      (rsp_end_sector),
      .active_entries      (active_entries_ff),
      .first_usable_sector (first_usable_ff),
      .last_usable_sector  (last_usable_ff),
      .empty_marker        (empty_marker_ff),
      .head                (chain[0]),
      .ctl                 (ctl)
   );

   `PEA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `PEA_ASSERT_IMPL(a_no_write_while_idle, clock, reset, ctl.wr_en || ctl.shift, !req_ready)
   `PEA_ASSERT_IMPL(a_error_zeroes, clock, reset, rsp_valid && (rsp_status != STATUS_OK), (rsp_byte_value == 64'd0) && (rsp_start_sector == 64'd0) && (rsp_end_sector == 64'd0))
   `PEA_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)

endmodule

// ===== verif/tb_partition_extent_allocator_core.sv =====
`timescale 1ns / 1ps
// Testbench for the partition extent allocator core: a directed table, then random items checked against a predictor.
module tb_partition_extent_allocator_core;
   import pea_pkg::*;

   localparam int ENTRIES = 128;
   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 9;
   localparam int IDLE_PERCENT = 31;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3);
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS = 148;
   localparam int CALM_PHASE = 4;
   localparam int REPORT_LIMIT = 40;
   localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN_LAST = 3'd7;
   localparam logic [63:0] ALL_ONES = {64{1'b1}};

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  found;
      logic [63:0] bytes;
      logic [63:0] first;
      logic [63:0] last;
   } extent_reply_t;

   typedef struct packed {
      bit            is_config;
      logic [63:0]   active;
      logic [63:0]   first_usable;
      logic [63:0]   last_usable;
      logic [63:0]   marker;
      logic [2:0]    cmd;
      logic [6:0]    index;
      logic [63:0]   size;
      bit            has_literal;
      extent_reply_t literal;
   } stimulus_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd = '0;
   logic [6:0]  req_entry_index = '0;
   logic [63:0] req_size_bytes = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_found_index;
   logic [63:0] rsp_byte_value;
   logic [63:0] rsp_start_sector;
   logic [63:0] rsp_end_sector;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0]   sector_starts [ENTRIES];
   logic [63:0]   sector_ends [ENTRIES];
   logic [7:0]    active_reg;
   logic [63:0]   first_usable_reg;
   logic [63:0]   last_usable_reg;
   logic [63:0]   marker_reg;
   extent_reply_t awaited_replies [$];
   stimulus_row_t directed_rows [$];
   extent_reply_t head_reply;
   int            mismatches = 0;
   int            idle_cycles = 0;
   bit            calm = 1'b0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   partition_extent_allocator_core #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_entry_index  (req_entry_index),
      .req_size_bytes   (req_size_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_found_index  (rsp_found_index),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_start_sector (rsp_start_sector),
      .rsp_end_sector   (rsp_end_sector),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   function automatic int live_entries();
      return (active_reg > ENTRIES) ? ENTRIES : int'(active_reg);
   endfunction

   function automatic bit entry_in_use(int i);
      return sector_starts[i] != marker_reg && sector_ends[i] != marker_reg;
   endfunction

   function automatic int lowest_free_entry();
      int count;
      count = live_entries();
      for (int i = 0; i < count; i++) begin
         if (!entry_in_use(i)) return i;
      end
      return -1;
   endfunction

   function automatic extent_reply_t execute_command(logic [2:0] cmd, logic [6:0] index,
                                                     logic [63:0] size);
      extent_reply_t reply;
      int            count;
      logic [63:0]   sectors;
      logic [63:0]   cand_first;
      logic [63:0]   cand_last;
      logic [64:0]   sum;
      bit            overflow;
      count = live_entries();
      reply = '0;
      reply.status = STATUS_OK;
      reply.found = index;
      overflow = 1'b0;
      if (cmd == CMD_FIND_FREE) begin
         reply.found = '0;
         reply.status = STATUS_NO_SPACE;
         for (int i = 0; i < count; i++) begin
            if (!entry_in_use(i)) begin
               reply.found = 7'(i);
               reply.status = STATUS_OK;
               break;
            end
         end
      end else if (cmd >= CMD_ALLOCATE && cmd <= CMD_RELEASE) begin
         if (int'(index) >= count) begin
            reply.status = STATUS_RANGE;
         end else if (cmd == CMD_ALLOCATE) begin
            sectors = (size >> SECTOR_SHIFT) + ((size[SECTOR_SHIFT-1:0] != 0) ? 64'd1 : 64'd0);
            if (sectors == 0) sectors = 64'd1;
            cand_first = first_usable_reg;
            sum = {1'b0, cand_first} + {1'b0, sectors - 64'd1};
            cand_last = sum[63:0];
            overflow = sum[64];
            for (int i = 0; i < count && !overflow; i++) begin
               if (entry_in_use(i) && (cand_first >= sector_starts[i] ||
                                       cand_last >= sector_starts[i])) begin
                  if (sector_ends[i] == ALL_ONES) begin
                     overflow = 1'b1;
                  end else begin
                     cand_first = sector_ends[i] + 64'd1;
                     sum = {1'b0, cand_first} + {1'b0, sectors - 64'd1};
                     cand_last = sum[63:0];
                     overflow = sum[64];
                  end
               end
            end
            if (overflow || cand_last > last_usable_reg) begin
               reply.status = STATUS_NO_SPACE;
            end else begin
               sector_starts[index] = cand_first;
               sector_ends[index] = cand_last;
               reply.first = cand_first;
               reply.last = cand_last;
            end
         end else begin
            reply.first = sector_starts[index];
            reply.last = sector_ends[index];
            if (cmd == CMD_READ_OFFSET) begin
               reply.bytes = reply.first << SECTOR_SHIFT;
            end else if (cmd == CMD_READ_SIZE) begin
               reply.bytes = (reply.last - reply.first + 64'd1) << SECTOR_SHIFT;
            end else begin
               sector_starts[index] = marker_reg;
               sector_ends[index] = marker_reg;
            end
         end
      end
      return reply;
   endfunction

   function automatic stimulus_row_t config_row(logic [63:0] active, logic [63:0] first,
                                                logic [63:0] last, logic [63:0] marker);
      stimulus_row_t row;
      row = '0;
      row.is_config = 1'b1;
      row.active = active;
      row.first_usable = first;
      row.last_usable = last;
      row.marker = marker;
      return row;
   endfunction

   function automatic stimulus_row_t checked_row(logic [2:0] cmd, logic [6:0] index,
                                                 logic [63:0] size);
      stimulus_row_t row;
      row = '0;
      row.cmd = cmd;
      row.index = index;
      row.size = size;
      return row;
   endfunction

   function automatic stimulus_row_t literal_row(logic [2:0] cmd, logic [6:0] index,
                                                 logic [63:0] size, logic [1:0] status,
                                                 logic [6:0] found, logic [63:0] bytes,
                                                 logic [63:0] first, logic [63:0] last);
      stimulus_row_t row;
      row = checked_row(cmd, index, size);
      row.has_literal = 1'b1;
      row.literal.status = status;
      row.literal.found = found;
      row.literal.bytes = bytes;
      row.literal.first = first;
      row.literal.last = last;
      return row;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) report_mismatch($sformatf("%s expected %h, got %h", name, want, got));
   endtask

   task automatic send_item(input logic [2:0] cmd, input logic [6:0] index,
                            input logic [63:0] size, input bit use_literal,
                            input extent_reply_t literal);
      extent_reply_t predicted;
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_entry_index <= index;
      req_size_bytes <= size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = execute_command(cmd, index, size);
      if (use_literal) awaited_replies.push_back(literal);
      else awaited_replies.push_back(predicted);
      @(negedge clock);
   endtask

   task automatic program_registers(input logic [63:0] active, input logic [63:0] first,
                                    input logic [63:0] last, input logic [63:0] marker);
      logic [63:0] values [4];
      values[CSR_ACTIVE_ENTRIES] = active;
      values[CSR_FIRST_USABLE] = first;
      values[CSR_LAST_USABLE] = last;
      values[CSR_EMPTY_MARKER] = marker;
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(negedge clock);
      for (int r = 0; r < 4; r++) begin
         csr_valid <= 1'b1;
         csr_index <= 2'(r);
         csr_data <= values[r];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (2'(r))
            CSR_ACTIVE_ENTRIES: active_reg = values[r][7:0];
            CSR_FIRST_USABLE: first_usable_reg = values[r];
            CSR_LAST_USABLE: last_usable_reg = values[r];
            CSR_EMPTY_MARKER: marker_reg = values[r];
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("result arrived with no item outstanding");
         end else begin
            head_reply = awaited_replies.pop_front();
            compare_field("status", 64'(head_reply.status), 64'(rsp_status));
            compare_field("found_index", 64'(head_reply.found), 64'(rsp_found_index));
            compare_field("byte_value", head_reply.bytes, rsp_byte_value);
            compare_field("start_sector", head_reply.first, rsp_start_sector);
            compare_field("end_sector", head_reply.last, rsp_end_sector);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      stimulus_row_t row;
      extent_reply_t unused_reply;
      int            count;
      int            free_slot;
      int            pick;
      logic [2:0]    cmd;
      logic [6:0]    index;
      logic [63:0]   size;
      logic [63:0]   active_pick;
      logic [63:0]   first_pick;
      logic [63:0]   last_pick;
      logic [63:0]   marker_pick;

      unused_reply = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         sector_starts[i] = ALL_ONES;
         sector_ends[i] = ALL_ONES;
      end
      active_reg = 8'd128;
      first_usable_reg = 64'd34;
      last_usable_reg = 64'd0;
      marker_reg = ALL_ONES;

      directed_rows.push_back(literal_row(CMD_FIND_FREE, 7'd0, 64'd0, STATUS_OK, 7'd0,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(literal_row(CMD_ALLOCATE, 7'd5, 64'd1, STATUS_NO_SPACE, 7'd5,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(literal_row(CMD_READ_OFFSET, 7'd127, ALL_ONES, STATUS_OK,
                                          7'd127, 64'hFFFF_FFFF_FFFF_FE00, ALL_ONES, ALL_ONES));
      directed_rows.push_back(literal_row(CMD_READ_SIZE, 7'd0, 64'd0, STATUS_OK, 7'd0,
                                          64'd512, ALL_ONES, ALL_ONES));
      directed_rows.push_back(literal_row(CMD_RELEASE, 7'd3, 64'd0, STATUS_OK, 7'd3,
                                          64'd0, ALL_ONES, ALL_ONES));
      directed_rows.push_back(literal_row(CMD_UNKNOWN_FIRST, 7'd9, 64'h1234, STATUS_OK, 7'd9,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(literal_row(CMD_UNKNOWN_LAST, 7'd127, ALL_ONES, STATUS_OK,
                                          7'd127, 64'd0, 64'd0, 64'd0));
      directed_rows.push_back(config_row(64'd4, 64'd34, 64'd1000, ALL_ONES));
      directed_rows.push_back(checked_row(CMD_ALLOCATE, 7'd0, 64'd0));
      directed_rows.push_back(checked_row(CMD_ALLOCATE, 7'd1, 64'd513));
      directed_rows.push_back(literal_row(CMD_ALLOCATE, 7'd4, 64'd1, STATUS_RANGE, 7'd4,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(literal_row(CMD_READ_SIZE, 7'd100, 64'd0, STATUS_RANGE, 7'd100,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(checked_row(CMD_ALLOCATE, 7'd2, ALL_ONES));
      directed_rows.push_back(checked_row(CMD_ALLOCATE, 7'd2, 64'd1));
      directed_rows.push_back(checked_row(CMD_ALLOCATE, 7'd3, 64'd5120));
      directed_rows.push_back(literal_row(CMD_FIND_FREE, 7'd0, 64'd0, STATUS_NO_SPACE, 7'd0,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(checked_row(CMD_ALLOCATE, 7'd0, 64'd1024));
      directed_rows.push_back(checked_row(CMD_READ_OFFSET, 7'd1, 64'd0));
      directed_rows.push_back(checked_row(CMD_RELEASE, 7'd1, 64'd0));
      directed_rows.push_back(checked_row(CMD_FIND_FREE, 7'd0, 64'd0));
      directed_rows.push_back(config_row(64'd0, 64'hFFFF_FFFF_FFFF_FFF0, ALL_ONES, ALL_ONES));
      directed_rows.push_back(literal_row(CMD_FIND_FREE, 7'd0, 64'd0, STATUS_NO_SPACE, 7'd0,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(literal_row(CMD_RELEASE, 7'd0, 64'd0, STATUS_RANGE, 7'd0,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(config_row(64'd255, 64'hFFFF_FFFF_FFFF_FFF0, ALL_ONES, ALL_ONES));
      directed_rows.push_back(literal_row(CMD_ALLOCATE, 7'd10, 64'd8704, STATUS_NO_SPACE,
                                          7'd10, 64'd0, 64'd0, 64'd0));
      directed_rows.push_back(checked_row(CMD_ALLOCATE, 7'd127, 64'd8192));
      directed_rows.push_back(checked_row(CMD_RELEASE, 7'd0, 64'd0));
      // Entry 0 now holds all-ones bounds, which count as used once the marker is zero.
      directed_rows.push_back(config_row(64'd128, ALL_ONES - 64'd3, ALL_ONES, 64'd0));
      directed_rows.push_back(literal_row(CMD_ALLOCATE, 7'd9, 64'd2048, STATUS_NO_SPACE, 7'd9,
                                          64'd0, 64'd0, 64'd0));
      directed_rows.push_back(config_row(64'd1, 64'd40000, ALL_ONES, 64'd40000));
      directed_rows.push_back(literal_row(CMD_ALLOCATE, 7'd0, 64'd1, STATUS_OK, 7'd0,
                                          64'd0, 64'd40000, 64'd40000));
      directed_rows.push_back(literal_row(CMD_FIND_FREE, 7'd0, 64'd0, STATUS_OK, 7'd0,
                                          64'd0, 64'd0, 64'd0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.is_config) begin
            program_registers(row.active, row.first_usable, row.last_usable, row.marker);
         end else begin
            send_item(row.cmd, row.index, row.size, row.has_literal, row.literal);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         active_pick = {$urandom, $urandom};
         case (phase)
            0: active_pick[7:0] = 8'd128;
            1: active_pick[7:0] = 8'd255;
            2: active_pick[7:0] = 8'd1;
            3: active_pick[7:0] = 8'd6;
            default: active_pick[7:0] = ($urandom_range(0, 9) < 6) ? 8'd128 :
                                        8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 7))
            0: first_pick = 64'd0;
            1: first_pick = {$urandom, $urandom};
            2: first_pick = ALL_ONES - 64'($urandom_range(0, 40000));
            default: first_pick = 64'($urandom_range(0, 3000));
         endcase
         case ($urandom_range(0, 7))
            0: last_pick = ALL_ONES;
            1: last_pick = {$urandom, $urandom};
            2: last_pick = first_pick + 64'($urandom_range(0, 64));
            default: last_pick = first_pick + 64'($urandom_range(2000, 400000));
         endcase
         if (last_pick < first_pick) last_pick = ALL_ONES;
         case ($urandom_range(0, 9))
            0: marker_pick = 64'd0;
            1: marker_pick = first_pick;
            2: marker_pick = {$urandom, $urandom};
            3: marker_pick = first_pick + 64'($urandom_range(1, 200));
            default: marker_pick = ALL_ONES;
         endcase
         program_registers(active_pick, first_pick, last_pick, marker_pick);
         calm = (phase == CALM_PHASE);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            count = live_entries();
            if (count > 0 && $urandom_range(0, 9) != 0) index = 7'($urandom_range(0, count - 1));
            else index = 7'($urandom_range(0, ENTRIES - 1));
            size = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
               cmd = CMD_FIND_FREE;
            end else if (pick < 50) begin
               cmd = CMD_ALLOCATE;
               free_slot = lowest_free_entry();
               if (free_slot >= 0 && $urandom_range(0, 1) == 1) index = 7'(free_slot);
               case ($urandom_range(0, 9))
                  0: size = 64'd0;
                  1: size = ALL_ONES;
                  2: size = {$urandom, $urandom};
                  3: size = 64'($urandom_range(1, 64)) << SECTOR_SHIFT;
                  default: size = 64'($urandom_range(0, 32768));
               endcase
            end else if (pick < 62) begin
               cmd = CMD_READ_OFFSET;
            end else if (pick < 74) begin
               cmd = CMD_READ_SIZE;
            end else if (pick < 94) begin
               cmd = CMD_RELEASE;
            end else begin
               cmd = 3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
            end
            send_item(cmd, index, size, 1'b0, unused_reply);
         end
      end

      calm = 1'b0;
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/pea_pkg.sv
design/pea_cell.sv
design/pea_ctrl.sv
design/partition_extent_allocator_core.sv
verif/tb_partition_extent_allocator_core.sv
